// ===== rtl/core/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants of the linear probing hash table: field widths,
// stream packing, operation, status and slot kind codes, controller states.
// ----------------------------------------------------------------------------
package lpht_pkg;

    // Field widths.
    localparam int MODE_W   = 2;
    localparam int KEY_W    = 32;
    localparam int HASH_W   = 32;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 8;
    localparam int COUNT_W  = 9;
    localparam int KIND_W   = 2;

    // One metadata entry holds the key above the slot kind.
    localparam int META_W = KEY_W + KIND_W;

    // Stream packing, first field in the lowest bits.
    localparam int IN_BITS     = MODE_W + KEY_W + HASH_W + VALUE_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = STATUS_W + 1 + VALUE_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int KEY_LSB   = MODE_W;
    localparam int HASH_LSB  = KEY_LSB + KEY_W;
    localparam int VALUE_LSB = HASH_LSB + HASH_W;

    // Reset value of the fill limit: three quarters of 256 slots.
    localparam logic [FILL_W-1:0] MAX_FILL_RESET = 8'd192;

    // Operation codes.
    localparam logic [MODE_W-1:0] MODE_GET = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SET = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEL = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

    // Slot kinds.
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LIVE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TOMB  = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE
    } state_t;

endpackage

// ===== rtl/core/lpht_ram.sv =====
// ----------------------------------------------------------------------------
// lpht_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/linear_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing key/value map with linear probing and tombstones.
// ----------------------------------------------------------------------------
// One transaction is a get, set or delete; each gives exactly one result. The
// block works on one transaction at a time and probes at least one and at
// most SLOTS slots for it: the probe reads one slot per cycle from the
// metadata memory, whose read is registered. A result waits in the output
// register while the next transaction is probed. After reset the block marks
// every slot empty and does not accept transactions during that time; the
// fill limit may be written at any time the block is idle. New keys that need
// an empty slot are refused with a full status once the count of non-empty
// slots would pass max_fill.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
    parameter int SLOTS = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                max_fill_we,
    input  logic [lpht_pkg::FILL_W-1:0]         max_fill_wdata,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: mode[1:0], key_id[31:0], key_hash[31:0],
    // new_value[63:0], zero fill.
    input  logic [lpht_pkg::IN_TDATA_W-1:0]     s_axis_tdata,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: status[1:0], was_new, found_value[63:0], zero fill.
    output logic [lpht_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    import lpht_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);

    // Control state.
    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      clr_cnt_reg;
    logic [FILL_W-1:0]     max_fill_reg;
    logic [COUNT_W-1:0]    used_count_reg;
    logic                  m_tvalid_reg;

    // Current transaction and probe position.
    logic [MODE_W-1:0]     mode_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [VALUE_W-1:0]    value_reg;
    logic [IDX_W-1:0]      at_reg;
    logic [IDX_W-1:0]      cnt_reg;
    logic                  tomb_seen_reg;
    logic [IDX_W-1:0]      tomb_at_reg;
    logic [OUT_BITS-1:0]   m_tdata_reg;

    // Memory ports.
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [META_W-1:0]     meta_rd;
    logic [VALUE_W-1:0]    data_rd;
    logic                  meta_we;
    logic                  data_we;
    logic [IDX_W-1:0]      wr_addr;
    logic [META_W-1:0]     meta_wdata;

    // Probe decision.
    logic [KIND_W-1:0]     kind_rd;
    logic [KEY_W-1:0]      key_rd;
    logic                  slot_empty;
    logic                  slot_tomb;
    logic                  slot_hit;
    logic                  tomb_found;
    logic [IDX_W-1:0]      tomb_slot;
    logic                  op_valid;
    logic                  probe_end;
    logic                  out_free;
    logic                  has_room;
    logic                  item_accept;
    logic                  probe_step;
    logic                  finish;
    logic                  used_inc;
    logic [STATUS_W-1:0]   res_status;
    logic                  res_new;
    logic [VALUE_W-1:0]    res_found;

    // Slot kind and key live in one memory, values in a second one read at
    // the same address so a hit on a get needs no further read.
    lpht_ram #(
        .WIDTH (META_W),
        .DEPTH (SLOTS)
    ) u_meta_ram (
        .clk     (aclk),
        .wr_en   (meta_we),
        .wr_addr (wr_addr),
        .wr_data (meta_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (meta_rd)
    );

    lpht_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (SLOTS)
    ) u_data_ram (
        .clk     (aclk),
        .wr_en   (data_we),
        .wr_addr (wr_addr),
        .wr_data (value_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (data_rd)
    );

    assign kind_rd    = meta_rd[KIND_W-1:0];
    assign key_rd     = meta_rd[META_W-1:KIND_W];
    assign slot_empty = (kind_rd == KIND_EMPTY);
    assign slot_tomb  = (kind_rd == KIND_TOMB);
    assign slot_hit   = !slot_empty && !slot_tomb && (key_rd == key_reg);
    assign tomb_found = tomb_seen_reg || slot_tomb;
    assign tomb_slot  = tomb_seen_reg ? tomb_at_reg : at_reg;
    assign op_valid   = (mode_reg == MODE_GET) || (mode_reg == MODE_SET) ||
                        (mode_reg == MODE_DEL);
    // The probe stops at an empty slot, at the key, after every slot, or at its first slot for an unused code.
    assign probe_end  = !op_valid || slot_empty || slot_hit || (&cnt_reg);
    assign out_free   = !m_tvalid_reg || m_axis_tready;
    assign has_room   = ((used_count_reg + COUNT_W'(1)) <= {1'b0, max_fill_reg});

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (&clr_cnt_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (probe_end && out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the state machine: memory accesses and the result.
    always_comb begin
        s_axis_tready = 1'b0;
        item_accept   = 1'b0;
        probe_step    = 1'b0;
        finish        = 1'b0;
        used_inc      = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = at_reg + IDX_W'(1);
        meta_we       = 1'b0;
        data_we       = 1'b0;
        wr_addr       = at_reg;
        meta_wdata    = {key_reg, KIND_LIVE};
        res_status    = STATUS_ABSENT;
        res_new       = 1'b0;
        res_found     = '0;
        case (state_reg)
            ST_CLEAR: begin
                meta_we    = 1'b1;
                wr_addr    = clr_cnt_reg;
                meta_wdata = {{KEY_W{1'b0}}, KIND_EMPTY};
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                item_accept   = s_axis_tvalid;
                rd_en         = s_axis_tvalid;
                rd_addr       = s_axis_tdata[HASH_LSB +: IDX_W];
            end
            ST_PROBE: begin
                if (!probe_end) begin
                    probe_step = 1'b1;
                    rd_en      = 1'b1;
                end else if (out_free) begin
                    finish = 1'b1;
                    case (mode_reg)
                        MODE_GET: begin
                            if (slot_hit) begin
                                res_status = STATUS_OK;
                                res_found  = data_rd;
                            end
                        end
                        MODE_DEL: begin
                            if (slot_hit) begin
                                res_status = STATUS_OK;
                                meta_we    = 1'b1;
                                meta_wdata = {key_reg, KIND_TOMB};
                            end
                        end
                        MODE_SET: begin
                            if (slot_hit) begin
                                res_status = STATUS_OK;
                                data_we    = 1'b1;
                            end else if (tomb_found) begin
                                // A tombstone is reused without a fill check.
                                res_status = STATUS_OK;
                                res_new    = 1'b1;
                                wr_addr    = tomb_slot;
                                meta_we    = 1'b1;
                                data_we    = 1'b1;
                            end else if (slot_empty && has_room) begin
                                res_status = STATUS_OK;
                                res_new    = 1'b1;
                                used_inc   = 1'b1;
                                meta_we    = 1'b1;
                                data_we    = 1'b1;
                            end else begin
                                res_status = STATUS_FULL;
                            end
                        end
                        default: begin
                            res_status = STATUS_ABSENT;
                        end
                    endcase
                end
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            max_fill_reg   <= MAX_FILL_RESET;
            used_count_reg <= '0;
            m_tvalid_reg   <= 1'b0;
            tomb_seen_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
            if (max_fill_we) begin
                max_fill_reg <= max_fill_wdata;
            end
            if (used_inc) begin
                used_count_reg <= used_count_reg + COUNT_W'(1);
            end
            if (finish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (item_accept) begin
                tomb_seen_reg <= 1'b0;
            end else if (probe_step && slot_tomb) begin
                tomb_seen_reg <= 1'b1;
            end
        end
    end

    // Transaction and probe registers.
    always_ff @(posedge aclk) begin
        if (item_accept) begin
            mode_reg  <= s_axis_tdata[MODE_W-1:0];
            key_reg   <= s_axis_tdata[KEY_LSB +: KEY_W];
            value_reg <= s_axis_tdata[VALUE_LSB +: VALUE_W];
            at_reg    <= s_axis_tdata[HASH_LSB +: IDX_W];
            cnt_reg   <= '0;
        end else if (probe_step) begin
            at_reg  <= at_reg + IDX_W'(1);
            cnt_reg <= cnt_reg + IDX_W'(1);
            if (!tomb_seen_reg && slot_tomb) begin
                tomb_at_reg <= at_reg;
            end
        end
        if (finish) begin
            m_tdata_reg <= {res_found, res_new, res_status};
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, m_tdata_reg};

    // The count of non-empty slots moves by at most one per cycle and only up.
    a_used_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |->
            (used_count_reg == $past(used_count_reg)) ||
            (used_count_reg == $past(used_count_reg) + COUNT_W'(1)))
        else $error("used_count changed by more than one");

    // The fill limit is eight bits wide, so the count never reaches 256.
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        !used_count_reg[COUNT_W-1])
        else $error("used_count exceeded the fill limit range");

    // An accepted transaction always goes on to probe.
    a_accept_probe: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == ST_PROBE))
        else $error("accepted transaction did not start a probe");

    // A new result appears only after a probe has ended.
    a_result_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_PROBE))
        else $error("result appeared without a probe");

    // No table write happens while a transaction is being accepted.
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!meta_we && !data_we))
        else $error("table written while idle");

endmodule

// ===== sim/lpht_checker.sv =====
// ----------------------------------------------------------------------------
// lpht_checker
// Watches both stream channels and the fill limit port of the hash table,
// keeps its own copy of the slot memory to predict one result per accepted
// transaction, and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module lpht_checker #(
    parameter int SLOTS = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                max_fill_we,
    input  logic [lpht_pkg::FILL_W-1:0]         max_fill_wdata,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    // Fields from bit 0: mode[1:0], key_id[31:0], key_hash[31:0],
    // new_value[63:0], zero fill.
    input  logic [lpht_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: status[1:0], was_new, found_value[63:0], zero fill.
    input  logic [lpht_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output int                                  awaited,
    output int                                  fail_count
);
    import lpht_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                was_new;
        logic [VALUE_W-1:0]  found_value;
    } result_t;

    logic [KEY_W-1:0]   held_key   [SLOTS];
    logic [VALUE_W-1:0] held_value [SLOTS];
    logic [KIND_W-1:0]  held_kind  [SLOTS];
    logic [COUNT_W-1:0] filled_slots;
    logic [FILL_W-1:0]  fill_limit;
    result_t            awaited_results [$];
    int                 err_cnt = 0;

    assign fail_count = err_cnt;

    task automatic clear_map();
        for (int i = 0; i < SLOTS; i++) begin
            held_key[i]   = '0;
            held_value[i] = '0;
            held_kind[i]  = KIND_EMPTY;
        end
        filled_slots = '0;
        fill_limit   = MAX_FILL_RESET;
        awaited_results.delete();
    endtask

    // Walks the probe path of one transaction, applies it to the map copy and
    // returns the result the block should give for it.
    function automatic result_t apply_to_map(logic [MODE_W-1:0] op, logic [KEY_W-1:0] key,
                                             logic [HASH_W-1:0] hash,
                                             logic [VALUE_W-1:0] val);
        result_t     r;
        int unsigned at;
        int unsigned stop_at;
        int unsigned tomb_at;
        bit          hit;
        bit          tomb_seen;
        bit          empty_seen;
        bit          done;
        r.status      = STATUS_ABSENT;
        r.was_new     = 1'b0;
        r.found_value = '0;
        hit        = 0;
        tomb_seen  = 0;
        empty_seen = 0;
        done       = 0;
        stop_at    = 0;
        tomb_at    = 0;
        at         = hash & (SLOTS - 1);
        for (int n = 0; n < SLOTS && !done; n++) begin
            if (held_kind[at] == KIND_EMPTY) begin
                empty_seen = 1;
                stop_at    = at;
                done       = 1;
            end else if (held_kind[at] == KIND_TOMB) begin
                if (!tomb_seen) begin
                    tomb_seen = 1;
                    tomb_at   = at;
                end
            end else if (held_key[at] == key) begin
                hit     = 1;
                stop_at = at;
                done    = 1;
            end
            if (!done) at = (at + 1) % SLOTS;
        end
        case (op)
            MODE_GET: begin
                if (hit) begin
                    r.status      = STATUS_OK;
                    r.found_value = held_value[stop_at];
                end
            end
            MODE_DEL: begin
                if (hit) begin
                    held_kind[stop_at] = KIND_TOMB;
                    r.status = STATUS_OK;
                end
            end
            MODE_SET: begin
                if (hit) begin
                    held_value[stop_at] = val;
                    r.status = STATUS_OK;
                end else if (tomb_seen) begin
                    // A reused tombstone was already counted, so no fill check.
                    held_kind[tomb_at]  = KIND_LIVE;
                    held_key[tomb_at]   = key;
                    held_value[tomb_at] = val;
                    r.status  = STATUS_OK;
                    r.was_new = 1'b1;
                end else if (empty_seen && int'(filled_slots) + 1 <= int'(fill_limit)) begin
                    held_kind[stop_at]  = KIND_LIVE;
                    held_key[stop_at]   = key;
                    held_value[stop_at] = val;
                    filled_slots = filled_slots + 1'b1;
                    r.status  = STATUS_OK;
                    r.was_new = 1'b1;
                end else begin
                    r.status = STATUS_FULL;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t seen;
        result_t want;
        if (!aresetn) begin
            clear_map();
        end else begin
            if (max_fill_we) fill_limit = max_fill_wdata;
            // The result of a transaction accepted at this edge cannot leave at
            // the same edge, so results are matched before new ones are queued.
            if (m_axis_tvalid && m_axis_tready) begin
                seen.status      = m_axis_tdata[STATUS_W-1:0];
                seen.was_new     = m_axis_tdata[STATUS_W];
                seen.found_value = m_axis_tdata[STATUS_W+1 +: VALUE_W];
                if (awaited_results.size() == 0) begin
                    $error("result with none awaited: status %0d was_new %0d found_value %h",
                           seen.status, seen.was_new, seen.found_value);
                    err_cnt++;
                end else begin
                    want = awaited_results.pop_front();
                    if (seen.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, seen.status);
                        err_cnt++;
                    end
                    if (seen.was_new !== want.was_new) begin
                        $error("was_new: expected %0d, got %0d", want.was_new, seen.was_new);
                        err_cnt++;
                    end
                    if (seen.found_value !== want.found_value) begin
                        $error("found_value: expected %h, got %h",
                               want.found_value, seen.found_value);
                        err_cnt++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                awaited_results.push_back(apply_to_map(s_axis_tdata[MODE_W-1:0],
                                                       s_axis_tdata[KEY_LSB +: KEY_W],
                                                       s_axis_tdata[HASH_LSB +: HASH_W],
                                                       s_axis_tdata[VALUE_LSB +: VALUE_W]));
            end
        end
        awaited <= awaited_results.size();
    end

endmodule

// ===== sim/tb_linear_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table
// Drives get, set and delete transactions into the hash table: a directed
// pass over wrap-around, collisions, tombstone reuse and the fill limit, then
// random traffic on clustered key pools under several fill limits and idle
// patterns. The checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table;
    import lpht_pkg::*;

    localparam int SLOTS       = 256;
    localparam int POOL        = 32;
    localparam int WINDOW      = 24;
    localparam int CYCLE_LIMIT = 3000000;

    // The unused operation code; the block must answer it as a miss.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   max_fill_we = 1'b0;
    logic [FILL_W-1:0]      max_fill_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int awaited;
    int fail_count;
    int send_idle_pct = 16;
    int recv_idle_pct = 87;
    int cycle_count = 0;

    logic [KEY_W-1:0]  pool_key  [POOL];
    logic [HASH_W-1:0] pool_hash [POOL];

    linear_probe_hash_table #(.SLOTS(SLOTS)) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .max_fill_we    (max_fill_we),
        .max_fill_wdata (max_fill_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata)
    );

    lpht_checker #(.SLOTS(SLOTS)) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .max_fill_we    (max_fill_we),
        .max_fill_wdata (max_fill_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .awaited        (awaited),
        .fail_count     (fail_count)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Returns right after the edge at which the transaction was accepted,
    // with tvalid still high so a back-to-back transaction needs no dip.
    task automatic send_op(input logic [MODE_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic [HASH_W-1:0] hash, input logic [VALUE_W-1:0] val);
        logic [IN_TDATA_W-1:0] word;
        word = '0;
        word[MODE_W-1:0]         = op;
        word[KEY_LSB +: KEY_W]   = key;
        word[HASH_LSB +: HASH_W] = hash;
        word[VALUE_LSB +: VALUE_W] = val;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited != 0) @(posedge aclk);
    endtask

    task automatic write_max_fill(input logic [FILL_W-1:0] limit);
        max_fill_we    <= 1'b1;
        max_fill_wdata <= limit;
        @(posedge aclk);
        max_fill_we    <= 1'b0;
    endtask

    // Keys of one pool share a narrow window of home slots so that probe
    // chains, collisions and tombstones build up quickly.
    task automatic new_pool(input logic [7:0] home_base);
        logic [HASH_W-1:0] h;
        for (int i = 0; i < POOL; i++) begin
            pool_key[i] = $urandom_range(1, 32'hFFFF_FFFF);
            h = $urandom;
            h[7:0] = home_base + 8'($urandom_range(0, WINDOW - 1));
            pool_hash[i] = h;
        end
    endtask

    task automatic random_op();
        int                pick;
        int                idx;
        logic [MODE_W-1:0] op;
        logic [KEY_W-1:0]  key;
        logic [HASH_W-1:0] hash;
        logic [VALUE_W-1:0] val;
        pick = $urandom_range(0, 99);
        idx  = $urandom_range(0, POOL - 1);
        key  = pool_key[idx];
        hash = pool_hash[idx];
        val  = {$urandom, $urandom};
        if (pick < 38) begin
            op = MODE_SET;
        end else if (pick < 68) begin
            op = MODE_GET;
        end else if (pick < 86) begin
            op = MODE_DEL;
        end else if (pick < 90) begin
            op = MODE_UNUSED;
        end else begin
            // Stray key anywhere in the table, with any operation code.
            op   = MODE_W'($urandom_range(0, 3));
            key  = $urandom_range(1, 32'hFFFF_FFFF);
            hash = $urandom;
        end
        send_op(op, key, hash, val);
    endtask

    task automatic run_random(input int count, input logic [FILL_W-1:0] limit,
                              input logic [7:0] home_base, input int s_idle, input int r_idle);
        wait_all_results();
        write_max_fill(limit);
        new_pool(home_base);
        send_idle_pct = s_idle;
        recv_idle_pct <= r_idle;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) wait_all_results();
            random_op();
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset fill limit: misses, the unused code, insert, overwrite, wrap.
        send_op(MODE_GET, 32'h0000_0001, 32'h0000_0000, 64'h0);
        send_op(MODE_DEL, 32'h0000_0001, 32'h0000_0000, 64'h0);
        send_op(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_op(MODE_SET, 32'h0000_0001, 32'h0000_0000, 64'h0);
        send_op(MODE_SET, 32'h0000_0001, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        send_op(MODE_GET, 32'h0000_0001, 32'h0000_0000, 64'h0);
        send_op(MODE_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF);
        send_op(MODE_SET, 32'h0000_0002, 32'h0000_00FF, 64'hA5A5_5A5A_0F0F_F0F0);
        send_op(MODE_GET, 32'h0000_0002, 32'h0000_00FF, 64'h0);
        // Tombstones: a probe must walk past them, and a new key reuses the first.
        send_op(MODE_DEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0);
        send_op(MODE_GET, 32'h0000_0002, 32'h0000_00FF, 64'h0);
        send_op(MODE_SET, 32'h0000_0003, 32'hABCD_EFFF, 64'h1111_2222_3333_4444);
        send_op(MODE_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0);
        send_op(MODE_DEL, 32'h0000_0001, 32'h0000_0000, 64'h0);
        send_op(MODE_DEL, 32'h0000_0001, 32'h0000_0000, 64'h0);
        send_op(MODE_SET, 32'h0000_0001, 32'h0000_0100, 64'h5555_AAAA_5555_AAAA);

        // Fill limit already reached: new keys are refused unless a tombstone
        // is free, while existing keys may still be overwritten.
        wait_all_results();
        write_max_fill(8'd1);
        send_op(MODE_SET, 32'h0000_0055, 32'h0000_0080, 64'h7);
        send_op(MODE_SET, 32'h0000_0002, 32'h0000_00FF, 64'h8000_0000_0000_0001);
        send_op(MODE_DEL, 32'h0000_0002, 32'h0000_00FF, 64'h0);
        send_op(MODE_SET, 32'h0000_0055, 32'h0000_00FF, 64'hDEAD_BEEF_0000_0055);
        send_op(MODE_GET, 32'h0000_0055, 32'h0000_00FF, 64'h0);

        // A zero limit refuses every set that needs an empty slot.
        wait_all_results();
        write_max_fill(8'd0);
        send_op(MODE_SET, 32'h0000_0066, 32'h0000_0040, 64'h66);
        send_op(MODE_GET, 32'h0000_0066, 32'h0000_0040, 64'h0);

        run_random(500, 8'd64, 8'hF0, 16, 87);
        run_random(500, 8'd255, 8'h60, 87, 16);
        run_random(500, FILL_W'($urandom_range(0, 255)), 8'(
                   $urandom_range(0, 255)), 0, 0);

        wait_all_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
